// ===== sv/intel_hex_record_parser_assert.svh =====
// Assertion helpers used by the parser module ihex_parse.
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

// Check a property on every rising edge, off while reset is asserted.
`define IHEX_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Check a property on every rising edge, reset included.
`define IHEX_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");

`endif

// ===== sv/ihex_pkg.sv =====
`default_nettype none

package ihex_pkg;

    localparam int CH_W     = 8;
    localparam int ADDR_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 16;
    localparam int DIGIT_W  = 10;
    localparam int NIB_W    = 4;

    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FORMAT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TYPE     = 3'd4;

    localparam logic [BYTE_W-1:0] TYPE_DATA = 8'h00;
    localparam logic [BYTE_W-1:0] TYPE_EOF  = 8'h01;

    // byte positions within a record
    localparam logic [DIGIT_W-2:0] BIDX_COUNT   = 9'd0;
    localparam logic [DIGIT_W-2:0] BIDX_ADDR_HI = 9'd1;
    localparam logic [DIGIT_W-2:0] BIDX_ADDR_LO = 9'd2;
    localparam logic [DIGIT_W-2:0] BIDX_TYPE    = 9'd3;
    localparam logic [DIGIT_W-1:0] BIDX_DATA    = 10'd4;

    localparam logic [DIGIT_W-1:0] HDR_DIGITS = 10'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 10'h3FF;

    typedef struct packed {
        logic              valid;
        logic [CH_W-1:0]   ch;
    } t_char_beat;

    typedef struct packed {
        logic                kind;
        logic [ADDR_W-1:0]   address;
        logic [BYTE_W-1:0]   data_byte;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   record_type;
        logic [BYTE_W-1:0]   record_count;
        logic [TOTAL_W-1:0]  total_bytes;
        logic                finished;
    } t_rec;

    // {is_hex, value}
    function automatic logic [NIB_W:0] hex_nibble(input logic [CH_W-1:0] c);
        logic [NIB_W:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ihex_char_if.sv =====
`default_nettype none

interface ihex_char_if;
    import ihex_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

// ===== sv/ihex_rec_if.sv =====
`default_nettype none

interface ihex_rec_if;
    import ihex_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [ADDR_W-1:0]   address;
    logic [BYTE_W-1:0]   data_byte;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   record_type;
    logic [BYTE_W-1:0]   record_count;
    logic [TOTAL_W-1:0]  total_bytes;
    logic                finished;

    modport source (
        output valid, output kind, output address, output data_byte, output status,
        output record_type, output record_count, output total_bytes, output finished,
        input ready
    );
    modport sink (
        input valid, input kind, input address, input data_byte, input status,
        input record_type, input record_count, input total_bytes, input finished,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/ihex_in_reg.sv =====
`default_nettype none

module ihex_in_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    ihex_char_if.sink             i_char,
    input  wire logic             i_advance,
    output ihex_pkg::t_char_beat  o_beat
);
    import ihex_pkg::*;

    logic            r_valid;
    logic [CH_W-1:0] r_ch;

    // take a new beat when empty or when the held one moves on
    assign i_char.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_ch <= i_char.ch;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.ch    = r_ch;

endmodule

`default_nettype wire

// ===== sv/ihex_parse.sv =====
`default_nettype none
`include "intel_hex_record_parser_assert.svh"

module ihex_parse (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  ihex_pkg::t_char_beat  i_beat,
    input  wire logic             i_out_free,
    output logic                  o_advance,
    output logic                  o_res_valid,
    output ihex_pkg::t_rec        o_res
);
    import ihex_pkg::*;

    logic                r_line_started, n_line_started;
    logic [DIGIT_W-1:0]  r_digit_index,  n_digit_index;
    logic [NIB_W-1:0]    r_high_nibble,  n_high_nibble;
    logic [BYTE_W-1:0]   r_byte_count,   n_byte_count;
    logic [ADDR_W-1:0]   r_base_address, n_base_address;
    logic [BYTE_W-1:0]   r_type_byte,    n_type_byte;
    logic [BYTE_W-1:0]   r_running_sum,  n_running_sum;
    logic                r_format_bad,   n_format_bad;
    logic [TOTAL_W-1:0]  r_loaded_total, n_loaded_total;
    logic                r_stopped,      n_stopped;

    logic                take;
    logic [NIB_W:0]      nib;
    logic [BYTE_W-1:0]   dec_byte;
    logic [DIGIT_W-2:0]  bidx;
    logic [DIGIT_W-1:0]  chk_idx;
    logic [DIGIT_W-1:0]  need;
    logic [STATUS_W-1:0] status;
    logic                end_fire;

    assign o_advance = i_out_free;
    assign take      = i_beat.valid && i_out_free && !r_stopped;
    assign nib       = hex_nibble(i_beat.ch);
    assign dec_byte  = {r_high_nibble, nib[NIB_W-1:0]};
    assign bidx      = r_digit_index[DIGIT_W-1:1];
    assign chk_idx   = {2'b00, r_byte_count} + BIDX_DATA;
    assign need      = HDR_DIGITS + {1'b0, r_byte_count, 1'b0};
    assign end_fire  = take && (i_beat.ch == CH_LF);

    always_comb begin
        if (r_format_bad || r_digit_index < HDR_DIGITS) begin
            status = ST_FORMAT;
        end else if (r_digit_index < need) begin
            status = ST_SHORT;
        end else if (r_running_sum != '0) begin
            status = ST_CHECKSUM;
        end else if (r_type_byte > TYPE_EOF) begin
            status = ST_TYPE;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        n_line_started = r_line_started;
        n_digit_index  = r_digit_index;
        n_high_nibble  = r_high_nibble;
        n_byte_count   = r_byte_count;
        n_base_address = r_base_address;
        n_type_byte    = r_type_byte;
        n_running_sum  = r_running_sum;
        n_format_bad   = r_format_bad;
        n_loaded_total = r_loaded_total;
        n_stopped      = r_stopped;

        o_res_valid        = 1'b0;
        o_res.kind         = KIND_DATA;
        o_res.address      = r_base_address + {7'd0, bidx} - ADDR_W'(BIDX_DATA);
        o_res.data_byte    = dec_byte;
        o_res.status       = ST_OK;
        o_res.record_type  = r_type_byte;
        o_res.record_count = r_byte_count;
        o_res.total_bytes  = r_loaded_total;
        o_res.finished     = r_stopped;

        if (take && i_beat.ch != CH_CR) begin
            if (i_beat.ch == CH_LF) begin
                if (status == ST_OK && r_type_byte == TYPE_DATA && r_byte_count != '0) begin
                    n_loaded_total = r_loaded_total + {8'd0, r_byte_count};
                end else begin
                    n_stopped = 1'b1;
                end
                o_res_valid       = 1'b1;
                o_res.kind        = KIND_END;
                o_res.address     = r_base_address;
                o_res.data_byte   = '0;
                o_res.status      = status;
                o_res.total_bytes = n_loaded_total;
                o_res.finished    = n_stopped;
                // drop the line context
                n_line_started = 1'b0;
                n_digit_index  = '0;
                n_high_nibble  = '0;
                n_byte_count   = '0;
                n_base_address = '0;
                n_type_byte    = '0;
                n_running_sum  = '0;
                n_format_bad   = 1'b0;
            end else if (!r_line_started) begin
                n_line_started = 1'b1;
                if (i_beat.ch != CH_COLON) begin
                    n_format_bad = 1'b1;
                end
            end else if (!nib[NIB_W]) begin
                n_format_bad = 1'b1;
            end else if (r_digit_index != DIGIT_MAX) begin
                n_digit_index = r_digit_index + 10'd1;
                if (!r_digit_index[0]) begin
                    n_high_nibble = nib[NIB_W-1:0];
                end else begin
                    unique case (bidx)
                        BIDX_COUNT: begin
                            n_byte_count  = dec_byte;
                            n_running_sum = r_running_sum + dec_byte;
                        end
                        BIDX_ADDR_HI: begin
                            n_base_address = {dec_byte, r_base_address[BYTE_W-1:0]};
                            n_running_sum  = r_running_sum + dec_byte;
                        end
                        BIDX_ADDR_LO: begin
                            n_base_address = {r_base_address[ADDR_W-1:BYTE_W], dec_byte};
                            n_running_sum  = r_running_sum + dec_byte;
                        end
                        BIDX_TYPE: begin
                            n_type_byte   = dec_byte;
                            n_running_sum = r_running_sum + dec_byte;
                        end
                        default: begin
                            if ({1'b0, bidx} < chk_idx) begin
                                // tentative data byte
                                n_running_sum = r_running_sum + dec_byte;
                                o_res_valid   = 1'b1;
                            end else if ({1'b0, bidx} == chk_idx) begin
                                n_running_sum = r_running_sum + dec_byte;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_started <= 1'b0;
            r_digit_index  <= '0;
            r_high_nibble  <= '0;
            r_byte_count   <= '0;
            r_base_address <= '0;
            r_type_byte    <= '0;
            r_running_sum  <= '0;
            r_format_bad   <= 1'b0;
            r_loaded_total <= '0;
            r_stopped      <= 1'b0;
        end else begin
            r_line_started <= n_line_started;
            r_digit_index  <= n_digit_index;
            r_high_nibble  <= n_high_nibble;
            r_byte_count   <= n_byte_count;
            r_base_address <= n_base_address;
            r_type_byte    <= n_type_byte;
            r_running_sum  <= n_running_sum;
            r_format_bad   <= n_format_bad;
            r_loaded_total <= n_loaded_total;
            r_stopped      <= n_stopped;
        end
    end

    `IHEX_ASSERT(a_no_res_when_stopped, i_clk, i_rst_n, r_stopped |-> !o_res_valid)
    `IHEX_ASSERT(a_stop_sticky, i_clk, i_rst_n, r_stopped |=> r_stopped)
    `IHEX_ASSERT(a_end_clears, i_clk, i_rst_n, end_fire |=> (r_digit_index == '0 && !r_line_started))
    `IHEX_ASSERT(a_total_only_at_end, i_clk, i_rst_n, !end_fire |=> $stable(r_loaded_total))
    `IHEX_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_loaded_total == '0 && !r_stopped))

endmodule

`default_nettype wire

// ===== sv/ihex_out_reg.sv =====
`default_nettype none

module ihex_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_res_valid,
    input  ihex_pkg::t_rec        i_res,
    output logic                  o_free,
    ihex_rec_if.source            o_rec
);
    import ihex_pkg::*;

    logic r_valid;
    t_rec r_rec;

    // free when empty or when the held beat is taken this cycle
    assign o_free = !r_valid || o_rec.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_rec <= i_res;
        end
    end

    assign o_rec.valid        = r_valid;
    assign o_rec.kind         = r_rec.kind;
    assign o_rec.address      = r_rec.address;
    assign o_rec.data_byte    = r_rec.data_byte;
    assign o_rec.status       = r_rec.status;
    assign o_rec.record_type  = r_rec.record_type;
    assign o_rec.record_count = r_rec.record_count;
    assign o_rec.total_bytes  = r_rec.total_bytes;
    assign o_rec.finished     = r_rec.finished;

endmodule

`default_nettype wire

// ===== sv/intel_hex_record_parser.sv =====
// An accepted character beat passes from the input register through the combinational parser;
// its result beat, if any, is registered in the result register, where the sink can take it.
// Throughput: one character per cycle while the sink takes each result beat without stalling.
// The figure is set by the single pass of nibble decode and 8-bit checksum add per character.
// Reset (synchronous, active low) clears the line context, the loaded total and the
// finished flag, and empties both registers; no clearing pass is needed.
`default_nettype none

module intel_hex_record_parser (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ihex_char_if.sink  i_char,
    ihex_rec_if.source o_rec
);
    import ihex_pkg::*;

    // Character register -> parser (state and result build) -> result register.
    // The parser works on the held character only when the result register can
    // take what it produces, so a stalled sink holds everything upstream.
    t_char_beat beat;
    t_rec       res;
    logic       res_valid;
    logic       advance;
    logic       out_free;

    // hold each arriving character for one pass
    ihex_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (i_char),
        .i_advance (advance),
        .o_beat    (beat)
    );

    // decode the character, advance the record context, build a data or status beat;
    // once the finished flag is set, drop every character until reset
    ihex_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_out_free  (out_free),
        .o_advance   (advance),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // hold the result beat until the sink takes it
    ihex_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_rec       (o_rec)
    );

endmodule

`default_nettype wire
